[rtl/spq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stable priority queue package
// Shared types and codes for the controller, the datapath and the checker.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int ValueW = 32;
  localparam int PrioW  = 8;

  // Operation codes carried in the command field of an input word.
  localparam logic CMD_ENQUEUE = 1'b0;
  localparam logic CMD_DEQUEUE = 1'b1;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } err_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic execute;
  } ctrl_cmd_t;

endpackage
`default_nettype wire

[rtl/spq_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stable priority queue controller
// Two-state sequencer: captures an accepted word, then runs the update and
// raises the result strobe in the following cycle.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  output logic                    out_valid,
  output spq_pkg::ctrl_cmd_t      cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r;
  logic   out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          out_valid_r <= 1'b0;
          if (start) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: begin
          out_valid_r <= 1'b0;
          state_r     <= S_IDLE;
        end
      endcase
    end
  end

  assign busy        = (state_r == S_EXEC);
  assign out_valid   = out_valid_r;
  assign cmd.capture = (state_r == S_IDLE) && start;
  assign cmd.execute = (state_r == S_EXEC);

endmodule
`default_nettype wire

[rtl/spq_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stable priority queue datapath
// A row of sorted entry registers with one priority comparator per entry;
// insert shifts the entries behind the new word; remove shifts the whole row.
// ----------------------------------------------------------------------------
module spq_datapath #(
  parameter int DEPTH = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire spq_pkg::ctrl_cmd_t          cmd,
  input  wire logic                        in_command,
  input  wire logic [spq_pkg::ValueW-1:0]  in_data_value,
  input  wire logic [spq_pkg::PrioW-1:0]   in_priority_level,
  output logic [spq_pkg::ValueW-1:0]       out_front_value,
  output logic                             out_is_empty,
  output logic                             out_is_full,
  output logic [1:0]                       out_error_code
);

  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  // Captured input word.
  logic                        command_r;
  logic [spq_pkg::ValueW-1:0]  value_r;
  logic [spq_pkg::PrioW-1:0]   prio_r;

  logic [spq_pkg::ValueW-1:0]  val_r   [DEPTH];
  logic [spq_pkg::PrioW-1:0]   pri_r   [DEPTH];
  logic [spq_pkg::ValueW-1:0]  val_nxt [DEPTH];
  logic [spq_pkg::PrioW-1:0]   pri_nxt [DEPTH];
  logic [CntW-1:0]             count_r;
  logic [CntW-1:0]             count_nxt;
  logic [DEPTH-1:0]            ge;
  spq_pkg::err_t               err_nxt;

  logic [spq_pkg::ValueW-1:0]  front_r;
  logic                        empty_r;
  logic                        full_r;
  logic [1:0]                  err_r;

  // Entries are sorted, so ge is a thermometer: ones for every valid entry
  // that stays ahead of the new word.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ge[i] = (CntW'(i) < count_r) && (pri_r[i] >= prio_r);
    end
  end

  always_comb begin
    count_nxt = count_r;
    err_nxt   = spq_pkg::ERR_OK;
    for (int i = 0; i < DEPTH; i++) begin
      val_nxt[i] = val_r[i];
      pri_nxt[i] = pri_r[i];
    end
    if (command_r == spq_pkg::CMD_ENQUEUE) begin
      if (count_r == CntFull) begin
        err_nxt = spq_pkg::ERR_FULL;
      end else begin
        count_nxt = count_r + 1'b1;
        if (!ge[0]) begin
          val_nxt[0] = value_r;
          pri_nxt[0] = prio_r;
        end
        for (int i = 1; i < DEPTH; i++) begin
          if (!ge[i]) begin
            if (ge[i-1]) begin
              val_nxt[i] = value_r;
              pri_nxt[i] = prio_r;
            end else begin
              val_nxt[i] = val_r[i-1];
              pri_nxt[i] = pri_r[i-1];
            end
          end
        end
      end
    end else begin
      if (count_r == '0) begin
        err_nxt = spq_pkg::ERR_EMPTY;
      end else begin
        count_nxt = count_r - 1'b1;
        for (int i = 0; i < DEPTH - 1; i++) begin
          val_nxt[i] = val_r[i+1];
          pri_nxt[i] = pri_r[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      command_r <= in_command;
      value_r   <= in_data_value;
      prio_r    <= in_priority_level;
    end
    if (cmd.execute) begin
      for (int i = 0; i < DEPTH; i++) begin
        val_r[i] <= val_nxt[i];
        pri_r[i] <= pri_nxt[i];
      end
      front_r <= (count_nxt == '0) ? '1 : val_nxt[0];
      empty_r <= (count_nxt == '0);
      full_r  <= (count_nxt == CntFull);
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.execute) begin
      count_r <= count_nxt;
    end
  end

  assign out_front_value = front_r;
  assign out_is_empty    = empty_r;
  assign out_is_full     = full_r;
  assign out_error_code  = err_r;

endmodule
`default_nettype wire

[rtl/stable_priority_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stable priority queue
// Bounded queue of DEPTH entries sorted by priority, first in first out among
// equal priorities.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. Every word is first
// captured, then goes through the parallel compare and shift of the
// entry row. Its result appears in the cycle right after that with out_valid
// high for exactly one cycle and must be taken then, since the receiver cannot
// stall. busy is already low in that cycle, so a new word may start while
// that result is shown. An empty queue reports a front value of all ones.
module stable_priority_queue #(
  parameter int DEPTH = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  output logic              busy,
  input  wire logic         in_command,
  input  wire logic [31:0]  in_data_value,
  input  wire logic [7:0]   in_priority_level,
  output logic              out_valid,
  output logic [31:0]       out_front_value,
  output logic              out_is_empty,
  output logic              out_is_full,
  output logic [1:0]        out_error_code
);

  spq_pkg::ctrl_cmd_t  cmd;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  spq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_command        (in_command),
    .in_data_value     (in_data_value),
    .in_priority_level (in_priority_level),
    .out_front_value   (out_front_value),
    .out_is_empty      (out_is_empty),
    .out_is_full       (out_is_full),
    .out_error_code    (out_error_code)
  );

endmodule
`default_nettype wire

[rtl/spq_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stable priority queue checker
// Port-level assertions on timing and result consistency, bound to the top.
// ----------------------------------------------------------------------------
module spq_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic [31:0] out_front_value,
  input wire logic        out_is_empty,
  input wire logic        out_is_full,
  input wire logic [1:0]  out_error_code
);

  // Every accepted word yields its result strobe once its update has run.
  a_result_timing: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("result strobe missing after an accepted word");

  // A result is never shown while the block is still working on a word.
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // An empty queue reports all ones as its front value.
  a_empty_front: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_empty) |-> (out_front_value == 32'hFFFF_FFFF))
    else $error("empty queue with a front value other than all ones");

  // A failed dequeue leaves an empty queue; a dropped enqueue leaves it full.
  a_error_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_error_code != spq_pkg::ERR_EMPTY) || out_is_empty) &&
                  ((out_error_code != spq_pkg::ERR_FULL) || out_is_full))
    else $error("error code disagrees with the queue flags");

endmodule

bind stable_priority_queue spq_checker u_spq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_front_value (out_front_value),
  .out_is_empty    (out_is_empty),
  .out_is_full     (out_is_full),
  .out_error_code  (out_error_code)
);
`default_nettype wire
